// File: rtl/core/trlrs_pkg.sv
// trip latch rearm supervisor package: register indexes, config, state and result types
// no dependencies; used by the interfaces and every module of the block
package trlrs_pkg;

  localparam int unsigned CntW = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CntW-1:0] Sat16 = 16'hFFFF;
  localparam logic [2:0] RearmToggles = 3'd5;

  typedef logic [CntW-1:0] cnt_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ERROR_BLINK   = 3'd0,
    REG_NORMAL_BLINK  = 3'd1,
    REG_FLASH_ON      = 3'd2,
    REG_ARM_HOLD      = 3'd3,
    REG_RESET_PULSE   = 3'd4,
    REG_REARM_STEP    = 3'd5,
    REG_TELEM_PERIOD  = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    cnt_t error_blink_ticks;
    cnt_t normal_blink_ticks;
    cnt_t flash_on_ticks;
    cnt_t arm_hold_ticks;
    cnt_t reset_pulse_ticks;
    cnt_t rearm_step_ticks;
    cnt_t telemetry_period_ticks;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    error_blink_ticks:      16'd200,
    normal_blink_ticks:     16'd4000,
    flash_on_ticks:         16'd50,
    arm_hold_ticks:         16'd1500,
    reset_pulse_ticks:      16'd100,
    rearm_step_ticks:       16'd100,
    telemetry_period_ticks: 16'd500
  };

  typedef struct packed {
    logic       trip_flag;
    logic       prev_trip_level;
    logic       led_state;
    cnt_t       blink_elapsed;
    cnt_t       flash_timer;
    logic       arm_held;
    cnt_t       arm_elapsed;
    cnt_t       pulse_timer;
    logic [2:0] rearm_step_count;
    cnt_t       rearm_timer;
    cnt_t       telemetry_elapsed;
  } state_t;

  localparam state_t StateReset = '0;

  typedef struct packed {
    logic fault_led;
    logic latch_reset;
    logic telemetry_due;
    logic tripped;
  } result_t;

  function automatic cnt_t inc_sat(input cnt_t v);
    return (v == Sat16) ? v : cnt_t'(v + 16'd1);
  endfunction

endpackage

// File: rtl/core/trlrs_if.sv
// channel interfaces of the trip latch rearm supervisor: tick, status and config write
// depends on trlrs_pkg for the config index and data widths
interface trlrs_tick_if;
  logic valid;
  logic ready;
  logic trip_level;
  logic arm_level;
  modport source (output valid, output trip_level, output arm_level, input ready);
  modport sink (input valid, input trip_level, input arm_level, output ready);
endinterface

interface trlrs_status_if;
  logic valid;
  logic ready;
  logic fault_led;
  logic latch_reset;
  logic telemetry_due;
  logic tripped;
  modport source (output valid, output fault_led, output latch_reset,
                  output telemetry_due, output tripped, input ready);
  modport sink (input valid, input fault_led, input latch_reset,
                input telemetry_due, input tripped, output ready);
endinterface

interface trlrs_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [trlrs_pkg::CfgIdxW-1:0]   index;
  logic [trlrs_pkg::CntW-1:0]      data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/trip_latch_rearm_supervisor_top.sv
// Trip latch rearm supervisor. Each tick transaction (trip and arm levels) yields exactly one
// status transaction. A tick is captured in an input register, processed by one pass of
// combinational update logic against the state register, and the status is then registered in
// the output register; one tick per clock is sustained, and a full output register
// stalls the input only when the status side stops taking transactions. Config writes are
// accepted every cycle and should be made while no tick is in flight.
module trip_latch_rearm_supervisor_top
  import trlrs_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  trlrs_tick_if.sink    tick,
  trlrs_status_if.source status,
  trlrs_cfg_if.sink     cfg
);

  cfg_t    regs;
  state_t  state;
  state_t  state_next;
  result_t res;
  result_t res_q;
  logic    in_valid;
  logic    in_trip;
  logic    in_arm;
  logic    out_valid;
  logic    advance;

  trlrs_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  trlrs_step u_step (
    .regs       (regs),
    .cur        (state),
    .trip_level (in_trip),
    .arm_level  (in_arm),
    .nxt        (state_next),
    .res        (res)
  );

  assign advance    = in_valid && (!out_valid || status.ready);
  assign tick.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (tick.ready) begin
      in_valid <= tick.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      in_trip <= tick.trip_level;
      in_arm  <= tick.arm_level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= StateReset;
      out_valid <= 1'b0;
    end else begin
      if (advance) state <= state_next;
      if (advance) begin
        out_valid <= 1'b1;
      end else if (status.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) res_q <= res;
  end

  assign status.valid         = out_valid;
  assign status.fault_led     = res_q.fault_led;
  assign status.latch_reset   = res_q.latch_reset;
  assign status.telemetry_due = res_q.telemetry_due;
  assign status.tripped       = res_q.tripped;

endmodule

// File: rtl/core/trlrs_cfg_regs.sv
// configuration register file of the trip latch rearm supervisor
// depends on trlrs_pkg and the trlrs_cfg_if interface
module trlrs_cfg_regs
  import trlrs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  trlrs_cfg_if.sink   cfg,
  output cfg_t        regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= CfgReset;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg_idx_t'(cfg.index))
        REG_ERROR_BLINK:  regs.error_blink_ticks      <= cfg.data;
        REG_NORMAL_BLINK: regs.normal_blink_ticks     <= cfg.data;
        REG_FLASH_ON:     regs.flash_on_ticks         <= cfg.data;
        REG_ARM_HOLD:     regs.arm_hold_ticks         <= cfg.data;
        REG_RESET_PULSE:  regs.reset_pulse_ticks      <= cfg.data;
        REG_REARM_STEP:   regs.rearm_step_ticks       <= cfg.data;
        REG_TELEM_PERIOD: regs.telemetry_period_ticks <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/core/trlrs_step.sv
// per-tick update of the supervisor: trip edge, timers, blink, arm hold, rearm, telemetry
// depends on trlrs_pkg; purely combinational
module trlrs_step
  import trlrs_pkg::*;
(
  input  cfg_t    regs,
  input  state_t  cur,
  input  logic    trip_level,
  input  logic    arm_level,
  output state_t  nxt,
  output result_t res
);

  always_comb begin
    state_t s;
    logic   due;
    s   = cur;
    due = 1'b0;

    // trip edge
    if (trip_level && !s.prev_trip_level) s.trip_flag = 1'b1;
    s.prev_trip_level = trip_level;

    // one-shot timers
    if (s.flash_timer != '0) begin
      s.flash_timer = cnt_t'(s.flash_timer - 16'd1);
      if (s.flash_timer == '0) s.led_state = 1'b1;
    end
    if (s.pulse_timer != '0) s.pulse_timer = cnt_t'(s.pulse_timer - 16'd1);

    s.blink_elapsed = inc_sat(s.blink_elapsed);

    if (s.rearm_step_count != '0) begin
      if (s.arm_held) s.arm_elapsed = inc_sat(s.arm_elapsed);
      s.rearm_timer = inc_sat(s.rearm_timer);
      if (s.rearm_timer >= regs.rearm_step_ticks) begin
        s.rearm_timer = '0;
        if (s.rearm_step_count < RearmToggles) begin
          s.led_state        = ~s.led_state;
          s.rearm_step_count = 3'(s.rearm_step_count + 3'd1);
        end else begin
          s.led_state        = 1'b1;
          s.rearm_step_count = '0;
        end
      end
    end else begin
      // blink decision
      if (s.trip_flag) begin
        if (s.blink_elapsed >= regs.error_blink_ticks) begin
          s.led_state     = ~s.led_state;
          s.blink_elapsed = '0;
        end
      end else if (s.blink_elapsed >= regs.normal_blink_ticks) begin
        s.led_state     = 1'b0;
        s.blink_elapsed = '0;
        s.flash_timer   = regs.flash_on_ticks;
      end

      // arm tracking
      priority if (arm_level && !s.arm_held) begin
        s.arm_held    = 1'b1;
        s.arm_elapsed = '0;
      end else if (!arm_level) begin
        s.arm_held = 1'b0;
      end else begin
        s.arm_elapsed = inc_sat(s.arm_elapsed);
      end

      // trip clear
      if (s.trip_flag && s.arm_held && (s.arm_elapsed >= regs.arm_hold_ticks)) begin
        s.trip_flag        = 1'b0;
        s.pulse_timer      = regs.reset_pulse_ticks;
        s.led_state        = ~s.led_state;
        s.rearm_step_count = 3'd1;
        s.rearm_timer      = '0;
      end
    end

    // telemetry
    s.telemetry_elapsed = inc_sat(s.telemetry_elapsed);
    if (s.telemetry_elapsed >= regs.telemetry_period_ticks) begin
      due                 = 1'b1;
      s.telemetry_elapsed = '0;
    end

    nxt               = s;
    res.fault_led     = s.led_state;
    res.latch_reset   = (s.pulse_timer != '0);
    res.telemetry_due = due;
    res.tripped       = s.trip_flag;
  end

endmodule
